// ===== design/imp_pkg.sv =====
// Package for the indexed max priority queue: payload structs, opcodes,
// status codes and size constants. Depends on nothing.
package imp_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int ID_W            = 8;
  localparam int ID_SPACE        = 1 << ID_W;
  localparam int PRIO_W          = 32;
  localparam int CAP_W           = 9;
  localparam int OCC_W           = 9;
  localparam int STATUS_W        = 3;
  localparam int OP_W            = 2;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Opcodes
  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_INCREASE = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ID      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_HIGHER  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [ID_W-1:0]          entry_id;
    logic signed [PRIO_W-1:0] priority_req;
  } imp_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [ID_W-1:0]          removed_id;
    logic signed [PRIO_W-1:0] removed_priority;
    logic [OCC_W-1:0]         occupancy;
  } imp_out_t;

endpackage

// ===== design/imp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module imp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/indexed_max_priority_queue.sv =====
// Top level of the indexed binary max-heap priority queue.
// Depends on imp_pkg and imp_ram.
//
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    imp_pkg::imp_in_t
// out_      output     out_valid/out_ready  imp_pkg::imp_out_t
// cfg_      input      cfg_valid/cfg_ready  capacity, 9 bits
//
// One request at a time. A request rejected at acceptance gives its result in the cycle after acceptance.
// Sift up checks, reads the parent and compares at each level; sift down checks, reads
// the left and right children, selects the higher and compares it with the key (one
// shared signed comparator, one read port on each memory).
// rst_n is synchronous: clears the valid map and count, sets capacity to 256.
// in_ready is low while a request is in progress or a result awaits transfer.
module indexed_max_priority_queue #(
  parameter int MAX_ENTRIES = imp_pkg::MAX_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  imp_pkg::imp_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output imp_pkg::imp_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [imp_pkg::CAP_W-1:0]       cfg_data
);

  localparam int SW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = SW + 2;
  localparam int IW = imp_pkg::ID_W;
  localparam int PW = imp_pkg::PRIO_W;

  // Sequencer state codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_CHK  = 4'd1;
  localparam logic [3:0] S_UP_RP   = 4'd2;
  localparam logic [3:0] S_UP_CMP  = 4'd3;
  localparam logic [3:0] S_INC_CHK = 4'd4;
  localparam logic [3:0] S_RM_RH   = 4'd5;
  localparam logic [3:0] S_RM_RP   = 4'd6;
  localparam logic [3:0] S_RM_LP   = 4'd7;
  localparam logic [3:0] S_SD_CHK  = 4'd8;
  localparam logic [3:0] S_SD_RR   = 4'd9;
  localparam logic [3:0] S_SD_PR   = 4'd10;
  localparam logic [3:0] S_SD_SEL  = 4'd11;
  localparam logic [3:0] S_SD_MV   = 4'd12;
  localparam logic [3:0] S_FIN     = 4'd13;

  logic [3:0]               state_r, state_nxt;
  logic [SW-1:0]            slot_r, slot_nxt;
  logic [IW-1:0]            id_r, id_nxt;
  logic [PW-1:0]            key_r, key_nxt;
  logic [IW-1:0]            lid_r, lid_nxt;
  logic [PW-1:0]            lp_r, lp_nxt;
  logic [IW-1:0]            cid_r, cid_nxt;
  logic                     has_r_r, has_r_nxt;
  logic                     bsel_r, bsel_nxt;
  logic [IW-1:0]            bid_r, bid_nxt;
  logic [PW-1:0]            bp_r, bp_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [imp_pkg::CAP_W-1:0] cap_r;
  logic [imp_pkg::ID_SPACE-1:0] present_r, present_nxt;
  logic [IW-1:0]            rm_id_r, rm_id_nxt;
  logic [PW-1:0]            rm_prio_r, rm_prio_nxt;
  logic                     out_valid_r;
  imp_pkg::imp_out_t        out_data_r;

  logic                     fin;
  logic [imp_pkg::STATUS_W-1:0] fin_status;

  // Memory ports
  logic            heap_we;
  logic [SW-1:0]   heap_waddr, heap_raddr;
  logic [IW-1:0]   heap_wdata, heap_rdata;
  logic            pos_we;
  logic [IW-1:0]   pos_waddr, pos_raddr;
  logic [SW-1:0]   pos_wdata, pos_rdata;
  logic            pri_we;
  logic [IW-1:0]   pri_waddr, pri_raddr;
  logic [PW-1:0]   pri_wdata, pri_rdata;

  // Shared signed comparator
  logic [PW-1:0]   cmp_a, cmp_b;
  logic            cmp_gt;
  assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

  // Tree arithmetic on the current slot
  logic [XW-1:0] lchild, rchild, cnt_x;
  logic [SW-1:0] parent;
  assign lchild = {1'b0, slot_r, 1'b1};
  assign rchild = lchild + XW'(1);
  assign cnt_x  = XW'(cnt_r);
  assign parent = (slot_r - SW'(1)) >> 1;

  logic accept, bad_id;
  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign bad_id    = ({1'b0, in_data.entry_id} >= cap_r) ||
                     (int'(in_data.entry_id) >= MAX_ENTRIES);

  imp_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rdata)
  );

  imp_ram #(.WIDTH(SW), .DEPTH(imp_pkg::ID_SPACE)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  imp_ram #(.WIDTH(PW), .DEPTH(imp_pkg::ID_SPACE)) u_pri (
    .clk(clk), .we(pri_we), .waddr(pri_waddr), .wdata(pri_wdata),
    .raddr(pri_raddr), .rdata(pri_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    id_nxt      = id_r;
    key_nxt     = key_r;
    lid_nxt     = lid_r;
    lp_nxt      = lp_r;
    cid_nxt     = cid_r;
    has_r_nxt   = has_r_r;
    bsel_nxt    = bsel_r;
    bid_nxt     = bid_r;
    bp_nxt      = bp_r;
    cnt_nxt     = cnt_r;
    present_nxt = present_r;
    rm_id_nxt   = rm_id_r;
    rm_prio_nxt = rm_prio_r;
    fin         = 1'b0;
    fin_status  = imp_pkg::ST_OK;
    heap_we     = 1'b0;
    heap_waddr  = slot_r;
    heap_wdata  = id_r;
    heap_raddr  = '0;
    pos_we      = 1'b0;
    pos_waddr   = id_r;
    pos_wdata   = slot_r;
    pos_raddr   = id_r;
    pri_we      = 1'b0;
    pri_waddr   = id_r;
    pri_wdata   = key_r;
    pri_raddr   = id_r;
    cmp_a       = key_r;
    cmp_b       = pri_rdata;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rm_id_nxt   = '0;
          rm_prio_nxt = '0;
          id_nxt      = in_data.entry_id;
          key_nxt     = in_data.priority_req;
          case (in_data.opcode)
            imp_pkg::OP_INSERT: begin
              if (bad_id) begin
                fin = 1'b1; fin_status = imp_pkg::ST_BAD_ID;
              end else if (present_r[in_data.entry_id]) begin
                fin = 1'b1; fin_status = imp_pkg::ST_PRESENT;
              end else if (cnt_r < CW'(MAX_ENTRIES)) begin
                pri_we      = 1'b1;
                pri_waddr   = in_data.entry_id;
                pri_wdata   = in_data.priority_req;
                present_nxt[in_data.entry_id] = 1'b1;
                slot_nxt    = SW'(cnt_r);
                cnt_nxt     = cnt_r + CW'(1);
                state_nxt   = S_UP_CHK;
              end else begin
                fin = 1'b1;
              end
            end
            imp_pkg::OP_INCREASE: begin
              if (bad_id) begin
                fin = 1'b1; fin_status = imp_pkg::ST_BAD_ID;
              end else if (!present_r[in_data.entry_id]) begin
                fin = 1'b1; fin_status = imp_pkg::ST_NOT_PRESENT;
              end else begin
                pri_raddr = in_data.entry_id;
                pos_raddr = in_data.entry_id;
                state_nxt = S_INC_CHK;
              end
            end
            imp_pkg::OP_REMOVE: begin
              if (cnt_r == '0) begin
                fin = 1'b1; fin_status = imp_pkg::ST_EMPTY;
              end else begin
                heap_raddr = '0;
                state_nxt  = S_RM_RH;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // Increase: new priority must beat the stored one
      S_INC_CHK: begin
        if (!cmp_gt) begin
          fin = 1'b1; fin_status = imp_pkg::ST_NOT_HIGHER;
          state_nxt = S_IDLE;
        end else begin
          pri_we    = 1'b1;
          slot_nxt  = pos_rdata;
          state_nxt = S_UP_CHK;
        end
      end

      // Sift up: fetch parent id and priority, compare, move the parent down
      S_UP_CHK: begin
        if (slot_r == '0) begin
          heap_we = 1'b1; pos_we = 1'b1;
          fin = 1'b1; state_nxt = S_IDLE;
        end else begin
          heap_raddr = parent;
          state_nxt  = S_UP_RP;
        end
      end
      S_UP_RP: begin
        pri_raddr = heap_rdata;
        lid_nxt   = heap_rdata;
        state_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (cmp_gt) begin
          heap_we    = 1'b1; heap_wdata = lid_r;
          pos_we     = 1'b1; pos_waddr  = lid_r;
          slot_nxt   = parent;
          state_nxt  = S_UP_CHK;
        end else begin
          heap_we = 1'b1; pos_we = 1'b1;
          fin = 1'b1; state_nxt = S_IDLE;
        end
      end

      // Remove: root id, then last entry
      S_RM_RH: begin
        rm_id_nxt  = heap_rdata;
        pri_raddr  = heap_rdata;
        present_nxt[heap_rdata] = 1'b0;
        cnt_nxt    = cnt_r - CW'(1);
        heap_raddr = SW'(cnt_r - CW'(1));
        state_nxt  = S_RM_RP;
      end
      S_RM_RP: begin
        rm_prio_nxt = pri_rdata;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          id_nxt    = heap_rdata;
          pri_raddr = heap_rdata;
          slot_nxt  = '0;
          state_nxt = S_RM_LP;
        end
      end
      S_RM_LP: begin
        key_nxt   = pri_rdata;
        state_nxt = S_SD_CHK;
      end

      // Sift down: fetch children, pick the higher, compare with the key
      S_SD_CHK: begin
        if (lchild >= cnt_x) begin
          heap_we = 1'b1; pos_we = 1'b1;
          fin = 1'b1; state_nxt = S_IDLE;
        end else begin
          heap_raddr = SW'(lchild);
          state_nxt  = S_SD_RR;
        end
      end
      S_SD_RR: begin
        lid_nxt    = heap_rdata;
        pri_raddr  = heap_rdata;
        heap_raddr = SW'(rchild);
        has_r_nxt  = rchild < cnt_x;
        state_nxt  = S_SD_PR;
      end
      S_SD_PR: begin
        lp_nxt    = pri_rdata;
        cid_nxt   = heap_rdata;
        pri_raddr = heap_rdata;
        state_nxt = S_SD_SEL;
      end
      S_SD_SEL: begin
        cmp_a = pri_rdata;
        cmp_b = lp_r;
        if (has_r_r && cmp_gt) begin
          bsel_nxt = 1'b1; bid_nxt = cid_r; bp_nxt = pri_rdata;
        end else begin
          bsel_nxt = 1'b0; bid_nxt = lid_r; bp_nxt = lp_r;
        end
        state_nxt = S_SD_MV;
      end
      S_SD_MV: begin
        cmp_a = bp_r;
        cmp_b = key_r;
        if (cmp_gt) begin
          heap_we   = 1'b1; heap_wdata = bid_r;
          pos_we    = 1'b1; pos_waddr  = bid_r;
          slot_nxt  = bsel_r ? SW'(rchild) : SW'(lchild);
          state_nxt = S_SD_CHK;
        end else begin
          heap_we = 1'b1; pos_we = 1'b1;
          fin = 1'b1; state_nxt = S_IDLE;
        end
      end

      S_FIN: begin
        fin = 1'b1; state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cap_r       <= imp_pkg::CAP_RESET;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      present_r <= present_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    id_r      <= id_nxt;
    key_r     <= key_nxt;
    lid_r     <= lid_nxt;
    lp_r      <= lp_nxt;
    cid_r     <= cid_nxt;
    has_r_r   <= has_r_nxt;
    bsel_r    <= bsel_nxt;
    bid_r     <= bid_nxt;
    bp_r      <= bp_nxt;
    rm_id_r   <= rm_id_nxt;
    rm_prio_r <= rm_prio_nxt;
    if (fin) begin
      out_data_r.status           <= fin_status;
      out_data_r.removed_id       <= rm_id_nxt;
      out_data_r.removed_priority <= rm_prio_nxt;
      out_data_r.occupancy        <= imp_pkg::OCC_W'(cnt_r);
    end
  end

endmodule
